// File: design/sds_pkg.sv
// shared types, constants and microcode table of the scan disk scheduler
package sds_pkg;

  localparam int TRACK_W = 16;
  localparam int SEEK_W = 22;
  localparam int PC_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DIR = 2'd2;

  localparam logic [TRACK_W-1:0] DISK_SIZE_RST = 16'd200;

  typedef struct packed {
    logic [TRACK_W-1:0] request_track;
    logic               batch_end;
  } in_item_t;

  typedef struct packed {
    logic [TRACK_W-1:0] served_track;
    logic [TRACK_W-1:0] step_distance;
    logic [SEEK_W-1:0]  seek_total;
    logic               overflow;
    logic               last_of_run;
  } out_item_t;

  // branch conditions of the sequencer
  typedef enum logic [2:0] {
    BR_NEXT     = 3'd0,
    BR_WAIT_END = 3'd1,
    BR_SCAN     = 3'd2,
    BR_BEST     = 3'd3,
    BR_GOTO     = 3'd4
  } br_t;

  // program steps
  localparam logic [PC_W-1:0] STEP_LOAD      = 4'd0;
  localparam logic [PC_W-1:0] STEP_SETUP     = 4'd1;
  localparam logic [PC_W-1:0] STEP_EQ_SCAN   = 4'd2;
  localparam logic [PC_W-1:0] STEP_LEGA_INIT = 4'd3;
  localparam logic [PC_W-1:0] STEP_LEGA_SCAN = 4'd4;
  localparam logic [PC_W-1:0] STEP_LEGA_PICK = 4'd5;
  localparam logic [PC_W-1:0] STEP_LEGB_INIT = 4'd6;
  localparam logic [PC_W-1:0] STEP_LEGB_SCAN = 4'd7;
  localparam logic [PC_W-1:0] STEP_LEGB_PICK = 4'd8;
  localparam logic [PC_W-1:0] STEP_FLUSH     = 4'd9;

  typedef struct packed {
    logic            ld_in;
    logic            init;
    logic            leg_ld;
    logic            leg_inv;
    logic            scan;
    logic            scan_eq;
    logic            pick;
    logic            flush;
    br_t             br;
    logic [PC_W-1:0] tgt;
  } ctrl_word_t;

  typedef struct packed {
    logic in_end;
    logic scan_done;
    logic best_v;
    logic hold;
  } seq_stat_t;

  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '0;
    cw.br = BR_GOTO;
    cw.tgt = STEP_LOAD;
    case (pc)
      STEP_LOAD: begin
        cw.ld_in = 1'b1;
        cw.br = BR_WAIT_END;
        cw.tgt = STEP_SETUP;
      end
      STEP_SETUP: begin
        cw.init = 1'b1;
        cw.br = BR_NEXT;
      end
      STEP_EQ_SCAN: begin
        cw.scan = 1'b1;
        cw.scan_eq = 1'b1;
        cw.br = BR_SCAN;
      end
      STEP_LEGA_INIT: begin
        cw.leg_ld = 1'b1;
        cw.br = BR_NEXT;
      end
      STEP_LEGA_SCAN: begin
        cw.scan = 1'b1;
        cw.br = BR_SCAN;
      end
      STEP_LEGA_PICK: begin
        cw.pick = 1'b1;
        cw.br = BR_BEST;
        cw.tgt = STEP_LEGA_INIT;
      end
      STEP_LEGB_INIT: begin
        cw.leg_ld = 1'b1;
        cw.leg_inv = 1'b1;
        cw.br = BR_NEXT;
      end
      STEP_LEGB_SCAN: begin
        cw.scan = 1'b1;
        cw.br = BR_SCAN;
      end
      STEP_LEGB_PICK: begin
        cw.pick = 1'b1;
        cw.br = BR_BEST;
        cw.tgt = STEP_LEGB_INIT;
      end
      STEP_FLUSH: begin
        cw.flush = 1'b1;
        cw.br = BR_GOTO;
        cw.tgt = STEP_LOAD;
      end
      default: begin
        cw.br = BR_GOTO;
        cw.tgt = STEP_LOAD;
      end
    endcase
    return cw;
  endfunction

endpackage

// File: design/sds_ram.sv
// generic single-port-write ram with registered read
module sds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/sds_ucode.sv
// microcode sequencer: step counter, control table and branch logic
module sds_ucode (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sds_pkg::seq_stat_t     stat,
  output sds_pkg::ctrl_word_t    cw
);

  import sds_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic [PC_W-1:0] pc_inc;

  assign cw = ucode_rom(pc_r);
  assign pc_inc = pc_r + 1'b1;

  always_comb begin
    pc_nxt = pc_r;
    case (cw.br)
      BR_NEXT: begin
        if (!stat.hold) pc_nxt = pc_inc;
      end
      BR_WAIT_END: begin
        if (stat.in_end) pc_nxt = cw.tgt;
      end
      BR_SCAN: begin
        if (stat.scan_done) pc_nxt = pc_inc;
      end
      BR_BEST: begin
        if (!stat.hold) pc_nxt = stat.best_v ? cw.tgt : pc_inc;
      end
      BR_GOTO: begin
        if (!stat.hold) pc_nxt = cw.tgt;
      end
      default: begin
        pc_nxt = STEP_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: design/sds_datapath.sv
// request store control, selection scan, seek arithmetic and result registers
module sds_datapath #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  sds_pkg::ctrl_word_t                                 cw,
  output sds_pkg::seq_stat_t                                  stat,
  input  logic                                                in_valid,
  output logic                                                in_stall,
  input  sds_pkg::in_item_t                                   in_data,
  output logic                                                out_valid,
  input  logic                                                out_stall,
  output sds_pkg::out_item_t                                  out_data,
  input  logic [15:0]                                         disk_size,
  input  logic [15:0]                                         start_head,
  input  logic                                                start_dir,
  output logic                                                ram_we,
  output logic [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1)-1:0] ram_waddr,
  output logic [15:0]                                         ram_wdata,
  output logic                                                ram_re,
  output logic [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1)-1:0] ram_raddr,
  input  logic [15:0]                                         ram_rdata
);

  import sds_pkg::*;

  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  logic [CW-1:0]           count_r, count_nxt;
  logic                    dropped_r, dropped_nxt;
  logic [TRACK_W-1:0]      head_r, head_nxt;
  logic [SEEK_W-1:0]       acc_r, acc_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    rd_v_r, rd_v_nxt;
  logic [AW-1:0]           rd_idx_r, rd_idx_nxt;
  logic [MAX_REQUESTS-1:0] used_r, used_nxt;
  logic                    end_used_r, end_used_nxt;
  logic                    leg_hi_r, leg_hi_nxt;
  logic                    best_v_r, best_v_nxt;
  logic [TRACK_W-1:0]      best_val_r, best_val_nxt;
  logic [AW-1:0]           best_idx_r, best_idx_nxt;
  logic                    best_end_r, best_end_nxt;
  logic                    pend_v_r, pend_v_nxt;
  out_item_t               pend_r, pend_nxt;
  logic                    out_v_r, out_v_nxt;
  out_item_t               out_r, out_nxt;

  logic               in_fire;
  logic               has_room;
  logic [TRACK_W-1:0] end_val;
  logic               issue;
  logic               eq_hit;
  logic               lo_ok;
  logic               hi_ok;
  logic               sel_take;
  logic               eq_visit;
  logic               pick_visit;
  logic               visit_req;
  logic [TRACK_W-1:0] visit_track;
  logic               push_ok;
  logic               blk;
  logic               visit_fire;
  logic               flush_fire;
  logic               freeze;
  logic               push;
  logic [TRACK_W-1:0] step_dist;
  logic [SEEK_W-1:0]  acc_sum;

  assign in_fire  = cw.ld_in && in_valid;
  assign in_stall = !cw.ld_in;
  assign has_room = count_r < CW'(MAX_REQUESTS);

  assign ram_we    = in_fire && has_room;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = in_data.request_track;

  // end track of the first sweep: disk size zero wraps to the top track
  assign end_val = start_dir ? (disk_size - 16'd1) : '0;

  assign issue = cw.scan && (idx_r < count_r);
  assign eq_hit = ram_rdata == start_head;
  assign lo_ok = !used_r[rd_idx_r] && (ram_rdata < start_head)
                 && (!best_v_r || ram_rdata > best_val_r);
  assign hi_ok = !used_r[rd_idx_r] && (ram_rdata > start_head)
                 && (!best_v_r || ram_rdata < best_val_r);
  assign sel_take = cw.scan && !cw.scan_eq && rd_v_r && (leg_hi_r ? hi_ok : lo_ok);

  assign eq_visit    = cw.scan && cw.scan_eq && rd_v_r && eq_hit;
  assign pick_visit  = cw.pick && best_v_r;
  assign visit_req   = eq_visit || pick_visit;
  assign visit_track = cw.pick ? best_val_r : ram_rdata;

  // the pending result moves to the output register when the next one is made or at flush
  assign push_ok    = !out_v_r || !out_stall;
  assign blk        = pend_v_r && !push_ok;
  assign visit_fire = visit_req && !blk;
  assign flush_fire = cw.flush && !blk;
  assign freeze     = eq_visit && blk;
  assign push       = (visit_fire || flush_fire) && pend_v_r;

  assign ram_re    = issue && !freeze;
  assign ram_raddr = idx_r[AW-1:0];

  assign step_dist = (visit_track > head_r) ? (visit_track - head_r)
                                            : (head_r - visit_track);
  assign acc_sum   = acc_r + SEEK_W'(step_dist);

  assign stat.in_end    = in_fire && in_data.batch_end;
  assign stat.scan_done = !rd_v_r && !issue;
  assign stat.best_v    = best_v_r;
  assign stat.hold      = (visit_req || cw.flush) && blk;

  always_comb begin
    count_nxt    = count_r;
    dropped_nxt  = dropped_r;
    head_nxt     = head_r;
    acc_nxt      = acc_r;
    idx_nxt      = idx_r;
    rd_v_nxt     = rd_v_r;
    rd_idx_nxt   = rd_idx_r;
    used_nxt     = used_r;
    end_used_nxt = end_used_r;
    leg_hi_nxt   = leg_hi_r;
    best_v_nxt   = best_v_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    best_end_nxt = best_end_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r;
    out_nxt      = out_r;

    if (in_fire) begin
      if (has_room) begin
        count_nxt = count_r + 1'b1;
      end else begin
        dropped_nxt = 1'b1;
      end
    end

    if (cw.init) begin
      head_nxt     = start_head;
      acc_nxt      = '0;
      idx_nxt      = '0;
      rd_v_nxt     = 1'b0;
      used_nxt     = '0;
      end_used_nxt = 1'b0;
      pend_v_nxt   = 1'b0;
    end

    // the first leg's selection pass starts with the end track as candidate until it is served
    if (cw.leg_ld) begin
      leg_hi_nxt   = start_dir ^ cw.leg_inv;
      idx_nxt      = '0;
      rd_v_nxt     = 1'b0;
      best_v_nxt   = !end_used_r && !cw.leg_inv;
      best_val_nxt = end_val;
      best_idx_nxt = '0;
      best_end_nxt = 1'b1;
    end

    if (cw.scan && !freeze) begin
      if (issue) begin
        rd_v_nxt   = 1'b1;
        rd_idx_nxt = idx_r[AW-1:0];
        idx_nxt    = idx_r + 1'b1;
      end else begin
        rd_v_nxt = 1'b0;
      end
    end

    if (sel_take) begin
      best_v_nxt   = 1'b1;
      best_val_nxt = ram_rdata;
      best_idx_nxt = rd_idx_r;
      best_end_nxt = 1'b0;
    end

    if (visit_fire) begin
      head_nxt                = visit_track;
      acc_nxt                 = acc_sum;
      pend_v_nxt              = 1'b1;
      pend_nxt.served_track   = visit_track;
      pend_nxt.step_distance  = step_dist;
      pend_nxt.seek_total     = acc_sum;
      pend_nxt.overflow       = dropped_r;
      pend_nxt.last_of_run    = 1'b0;
      if (pick_visit) begin
        if (best_end_r) begin
          end_used_nxt = 1'b1;
        end else begin
          used_nxt[best_idx_r] = 1'b1;
        end
      end
    end

    if (flush_fire) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
      pend_v_nxt  = 1'b0;
    end

    if (push) begin
      out_v_nxt           = 1'b1;
      out_nxt             = pend_r;
      out_nxt.last_of_run = cw.flush;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      dropped_r  <= 1'b0;
      idx_r      <= '0;
      rd_v_r     <= 1'b0;
      used_r     <= '0;
      end_used_r <= 1'b0;
      leg_hi_r   <= 1'b0;
      best_v_r   <= 1'b0;
      best_end_r <= 1'b0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      dropped_r  <= dropped_nxt;
      idx_r      <= idx_nxt;
      rd_v_r     <= rd_v_nxt;
      used_r     <= used_nxt;
      end_used_r <= end_used_nxt;
      leg_hi_r   <= leg_hi_nxt;
      best_v_r   <= best_v_nxt;
      best_end_r <= best_end_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r     <= head_nxt;
    acc_r      <= acc_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_REQUESTS))
    else $error("request count beyond capacity");

  a_read_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (CW'(rd_idx_r) < count_r))
    else $error("scan read outside the loaded batch");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    flush_fire |=> (count_r == '0) && !dropped_r && !pend_v_r)
    else $error("batch state not cleared after final result");

  a_end_once: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.pick && best_v_r && best_end_r) |-> !end_used_r)
    else $error("end track selected twice");

endmodule

// File: design/scan_disk_scheduler.sv
// top level of the scan disk scheduler: configuration registers and unit wiring
//
// Requests are taken one per cycle while in the load step, into a store of MAX_REQUESTS
// tracks; requests past capacity are dropped and flag overflow on every result of the
// batch. The request marked batch_end starts scheduling and input stalls until the last
// result is handed to the output register. Scheduling is run by a ten-step microprogram
// over one store read port: one pass over the batch serves requests equal to start_head,
// then every further track takes a selection pass that reads the whole batch; an output
// stall holds the sequencer. The disk end on the side of the first sweep is always
// visited. The store needs no clearing after reset.
module scan_disk_scheduler #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sds_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sds_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sds_pkg::out_item_t                  out_data
);

  import sds_pkg::*;

  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  logic [TRACK_W-1:0] disk_size_r, disk_size_nxt;
  logic [TRACK_W-1:0] start_head_r, start_head_nxt;
  logic               start_dir_r, start_dir_nxt;

  ctrl_word_t         cw;
  seq_stat_t          stat;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [TRACK_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [TRACK_W-1:0] ram_rdata;

  always_comb begin
    disk_size_nxt  = disk_size_r;
    start_head_nxt = start_head_r;
    start_dir_nxt  = start_dir_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DISK_SIZE:  disk_size_nxt = cfg_wdata;
        CFG_START_HEAD: start_head_nxt = cfg_wdata;
        CFG_START_DIR:  start_dir_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_size_r  <= DISK_SIZE_RST;
      start_head_r <= '0;
      start_dir_r  <= 1'b0;
    end else begin
      disk_size_r  <= disk_size_nxt;
      start_head_r <= start_head_nxt;
      start_dir_r  <= start_dir_nxt;
    end
  end

  sds_ucode u_ucode (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw)
  );

  sds_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cw         (cw),
    .stat       (stat),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .disk_size  (disk_size_r),
    .start_head (start_head_r),
    .start_dir  (start_dir_r),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  sds_ram #(
    .WIDTH (TRACK_W),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
